>>> rtl/u8chk_pkg.sv
`default_nettype none

package u8chk_pkg;

  // byte class decided by the front stage
  typedef enum logic [2:0] {
    CL_PLAIN   = 3'd0,  // 0x00-0x7f other than newline
    CL_NL      = 3'd1,  // 0x0a
    CL_CONT    = 3'd2,  // 0x80-0xbf
    CL_BADLEAD = 3'd3,  // 0xc0-0xc1
    CL_LEAD2   = 3'd4,  // 0xc2-0xdf
    CL_LEAD3   = 3'd5,  // 0xe0-0xef
    CL_LEAD4   = 3'd6,  // 0xf0-0xf4
    CL_BAD     = 3'd7   // 0xf5-0xff
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic present;
    logic last;
  } item_t;

  localparam logic [7:0] BYTE_NL     = 8'h0a;
  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] CONT_HI     = 8'hbf;
  localparam logic [7:0] BADLEAD_HI  = 8'hc1;
  localparam logic [7:0] LEAD2_LO    = 8'hc2;
  localparam logic [7:0] LEAD2_HI    = 8'hdf;
  localparam logic [7:0] LEAD3_LO    = 8'he0;
  localparam logic [7:0] LEAD3_HI    = 8'hef;
  localparam logic [7:0] LEAD4_LO    = 8'hf0;
  localparam logic [7:0] LEAD4_HI    = 8'hf4;
  localparam logic [7:0] BAD_LO      = 8'hf5;

  localparam logic [1:0] OWED_NONE   = 2'd0;
  localparam logic [1:0] OWED_LEAD2  = 2'd1;
  localparam logic [1:0] OWED_LEAD3  = 2'd2;
  localparam logic [1:0] OWED_LEAD4  = 2'd3;

endpackage

`default_nettype wire

>>> rtl/u8chk_in_if.sv
`default_nettype none

interface u8chk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_string;

  modport source (output valid, data_byte, byte_present, end_of_string, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_string, output ready);
endinterface

`default_nettype wire

>>> rtl/u8chk_out_if.sv
`default_nettype none

interface u8chk_out_if;
  logic valid;
  logic ready;
  logic is_invalid;
  logic has_newline;

  modport source (output valid, is_invalid, has_newline, input ready);
  modport sink   (input valid, is_invalid, has_newline, output ready);
endinterface

`default_nettype wire

>>> rtl/u8chk_front.sv
`default_nettype none

module u8chk_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  u8chk_in_if.sink            in_ch,
  output u8chk_pkg::item_t    push_item,
  output logic                push_valid,
  input  wire logic           push_ready
);

  logic             valid_r;
  u8chk_pkg::item_t item_r;
  u8chk_pkg::cls_t  cls;
  logic [7:0]       b;

  assign b = in_ch.data_byte;

  always_comb begin
    if (b == u8chk_pkg::BYTE_NL) begin
      cls = u8chk_pkg::CL_NL;
    end else if (b < u8chk_pkg::CONT_LO) begin
      cls = u8chk_pkg::CL_PLAIN;
    end else if (b <= u8chk_pkg::CONT_HI) begin
      cls = u8chk_pkg::CL_CONT;
    end else if (b <= u8chk_pkg::BADLEAD_HI) begin
      cls = u8chk_pkg::CL_BADLEAD;
    end else if (b >= u8chk_pkg::LEAD2_LO && b <= u8chk_pkg::LEAD2_HI) begin
      cls = u8chk_pkg::CL_LEAD2;
    end else if (b >= u8chk_pkg::LEAD3_LO && b <= u8chk_pkg::LEAD3_HI) begin
      cls = u8chk_pkg::CL_LEAD3;
    end else if (b >= u8chk_pkg::LEAD4_LO && b <= u8chk_pkg::LEAD4_HI) begin
      cls = u8chk_pkg::CL_LEAD4;
    end else begin
      cls = u8chk_pkg::CL_BAD;  // BAD_LO and up
    end
  end

  // stage empties into the queue while taking the next item
  assign in_ch.ready = !valid_r || push_ready;
  assign push_valid  = valid_r;
  assign push_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.cls     <= cls;
      item_r.present <= in_ch.byte_present;
      item_r.last    <= in_ch.end_of_string;
    end
  end

endmodule

`default_nettype wire

>>> rtl/u8chk_queue.sv
`default_nettype none

module u8chk_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire u8chk_pkg::item_t push_item,
  input  wire logic             push_valid,
  output logic                  push_ready,
  output u8chk_pkg::item_t      pop_item,
  output logic                  pop_valid,
  input  wire logic             pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8chk_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push;
  logic               pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/u8chk_back.sv
`default_nettype none

module u8chk_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire u8chk_pkg::item_t pop_item,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  u8chk_out_if.source           out_ch
);

  logic [1:0] owed_r, owed_nxt;
  logic       failed_r, failed_nxt;
  logic       nl_r, nl_nxt;
  logic       out_valid_r;
  logic       invalid_r;
  logic       newline_r;
  logic       pop;

  // a last item waits only while a report is stuck in the output register
  assign pop_ready = !pop_item.last || !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    owed_nxt   = owed_r;
    failed_nxt = failed_r;
    nl_nxt     = nl_r;
    if (pop_item.present && !failed_r) begin
      if (owed_r != u8chk_pkg::OWED_NONE) begin
        if (pop_item.cls == u8chk_pkg::CL_CONT) begin
          owed_nxt = owed_r - 2'd1;
        end else begin
          failed_nxt = 1'b1;
        end
      end else begin
        unique case (pop_item.cls) inside
          u8chk_pkg::CL_PLAIN: ;
          u8chk_pkg::CL_NL:    nl_nxt   = 1'b1;
          u8chk_pkg::CL_LEAD2: owed_nxt = u8chk_pkg::OWED_LEAD2;
          u8chk_pkg::CL_LEAD3: owed_nxt = u8chk_pkg::OWED_LEAD3;
          u8chk_pkg::CL_LEAD4: owed_nxt = u8chk_pkg::OWED_LEAD4;
          u8chk_pkg::CL_CONT, u8chk_pkg::CL_BADLEAD, u8chk_pkg::CL_BAD:
            failed_nxt = 1'b1;
          default: failed_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r      <= u8chk_pkg::OWED_NONE;
      failed_r    <= 1'b0;
      nl_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready) out_valid_r <= 1'b0;
      if (pop) begin
        if (pop_item.last) begin
          owed_r      <= u8chk_pkg::OWED_NONE;
          failed_r    <= 1'b0;
          nl_r        <= 1'b0;
          out_valid_r <= 1'b1;
        end else begin
          owed_r   <= owed_nxt;
          failed_r <= failed_nxt;
          nl_r     <= nl_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_item.last) begin
      invalid_r <= failed_nxt || (owed_nxt != u8chk_pkg::OWED_NONE);
      newline_r <= nl_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_invalid  = invalid_r;
  assign out_ch.has_newline = newline_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_item.last) |=> (owed_r == u8chk_pkg::OWED_NONE) && !failed_r && !nl_r)
    else $error("string state not cleared after report");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && !(pop && pop_item.last)) |=> failed_r)
    else $error("failure flag dropped inside a string");

  a_report_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(pop && pop_item.last))
    else $error("report without an end item");

  a_nl_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && !nl_r && !(pop && pop_item.last)) |=> !nl_r)
    else $error("newline flag changed after failure");

endmodule

`default_nettype wire

>>> rtl/utf8_string_checker.sv
// Path: an end item passes the front register, the queue write and the back state
//   update into the output register, where its result is then valid.
// Throughput: 1 item per cycle while the queue has room and no report is held.
// Items without an end mark produce no result; queue holds QUEUE_DEPTH items.
// Reset (rst_n low, synchronous) empties front, queue and output; string state clears.
`default_nettype none

module utf8_string_checker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  u8chk_in_if.sink     in_ch,
  u8chk_out_if.source  out_ch
);

  u8chk_pkg::item_t push_item;
  logic             push_valid;
  logic             push_ready;
  u8chk_pkg::item_t pop_item;
  logic             pop_valid;
  logic             pop_ready;

  u8chk_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  u8chk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  u8chk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
